// ===== hw/rtl/arp_cache_responder_assert.svh =====
// ---------------------------------------------------------------------------
// ARP cache assertion macros
// Clocked assertion shorthands used by the ARP cache table RTL.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("arpc assertion failed");

// Check that cons holds in the cycle after ante.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("arpc assertion failed");

`endif

// ===== hw/rtl/arpc_pkg.sv =====
// ---------------------------------------------------------------------------
// ARP cache package
// Payload types, status codes and protocol constants.
// ---------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	localparam logic [1:0] KIND_PACKET = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [15:0] ARP_MIN_LEN  = 16'd28;
	localparam logic [15:0] HTYPE_ETH    = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  HLEN_ETH     = 8'd6;
	localparam logic [7:0]  PLEN_IPV4    = 8'd4;
	localparam logic [15:0] OPER_REQUEST = 16'd1;

	localparam logic [1:0] TX_OPER_NONE    = 2'd0;
	localparam logic [1:0] TX_OPER_REQUEST = 2'd1;
	localparam logic [1:0] TX_OPER_REPLY   = 2'd2;

	localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

	localparam logic [7:0] CFG_OWN_MAC = 8'd0;
	localparam logic [7:0] CFG_OWN_IP  = 8'd1;

	typedef enum logic [2:0] {
		ST_DROP    = 3'd0,
		ST_LEARNED = 3'd1,
		ST_REPLIED = 3'd2,
		ST_HIT     = 3'd3,
		ST_MISS    = 3'd4,
		ST_REQUEST = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] frame_length;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] operation;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [47:0] found_mac;
		logic        tx_valid;
		logic [47:0] tx_dest_mac;
		logic [1:0]  tx_oper;
		logic [47:0] tx_target_mac;
		logic [31:0] tx_target_ip;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [47:0] value;
	} cfg_t;

	// Table update command from the top level.
	typedef struct packed {
		logic        en;
		logic [47:0] mac;
	} learn_t;

	// Table search result.
	typedef struct packed {
		logic        hit;
		logic [47:0] mac;
	} look_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arpc_chan_if.sv =====
// ---------------------------------------------------------------------------
// ARP cache channel interface
// Valid/ready channel carrying one payload of type T.
// ---------------------------------------------------------------------------
`default_nettype none

interface arpc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/arpc_table.sv =====
// ---------------------------------------------------------------------------
// ARP cache binding table
// Parallel-compare IPv4-to-MAC table with first-free allocation.
// ---------------------------------------------------------------------------
`default_nettype none

`include "arp_cache_responder_assert.svh"

module arpc_table #(
	parameter int ENTRIES = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [31:0]     key,
	input  wire arpc_pkg::learn_t learn,
	output arpc_pkg::look_t      look
);
	import arpc_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        ip_q  [ENTRIES];
	logic [47:0]        mac_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   free_idx;
	logic               free_found;
	logic [47:0]        hit_mac;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (ip_q[i] == key);
		end
	end

	// Scan downward so the lowest-numbered entry wins.
	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		free_found = 1'b0;
		hit_mac    = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
			hit_mac = hit_mac | (match[i] ? mac_q[i] : 48'd0);
		end
	end

	assign look.hit = |match;
	assign look.mac = hit_mac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (learn.en && !look.hit && free_found) begin
			valid_q[free_idx] <= 1'b1;
		end
	end

	// Update an existing binding, else fill the first free entry; drop when full.
	always_ff @(posedge clk) begin
		if (learn.en) begin
			if (look.hit) begin
				mac_q[hit_idx] <= learn.mac;
			end else if (free_found) begin
				ip_q[free_idx]  <= key;
				mac_q[free_idx] <= learn.mac;
			end
		end
	end

	`ARPC_ASSERT(a_single_match, clk, arst_n, $onehot0(match))
	`ARPC_ASSERT_NEXT(a_valid_sticky, clk, arst_n, 1'b1,
		(valid_q & $past(valid_q)) == $past(valid_q))
	`ARPC_ASSERT_NEXT(a_one_alloc, clk, arst_n, 1'b1,
		$countones(valid_q) <= $countones($past(valid_q)) + 1)

endmodule

`default_nettype wire

// ===== hw/rtl/arp_cache_responder.sv =====
// ---------------------------------------------------------------------------
// ARP cache and responder
// Learns sender bindings from ARP packets, answers requests for own IP,
// serves table lookups and builds broadcast queries.
// ---------------------------------------------------------------------------
// Pipeline: the input register loads when the request is accepted, and the
//   result register loads from it when the input stage advances.
// Throughput: 1 request per cycle unless the result is held; the table search
//   and update finish in the single compare stage between the two registers.
// Reset: arst_n clears the table valid bits, own_ip and both stage valids.
`default_nettype none

module arp_cache_responder #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	arpc_chan_if.sink   req,
	arpc_chan_if.source rsp,
	arpc_chan_if.sink   cfg
);
	import arpc_pkg::*;

	// Input stage
	req_t req_s1;
	logic vld_s1;

	// Result register
	rsp_t rsp_q;
	logic rsp_vld_q;

	logic [31:0] own_ip_q;

	logic   advance;
	logic   hdr_ok;
	logic   reply;
	logic   [31:0] key;
	learn_t learn;
	look_t  look;
	rsp_t   rsp_d;

	// Config writes always complete. own_mac is the sender address of
	// transmitted frames, which are built outside this block, so drop it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg.valid && cfg.data.index == CFG_OWN_IP) begin
			own_ip_q <= cfg.data.value[31:0];
		end
	end

	// Advance the input stage whenever the result register is free or drains.
	assign advance   = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// Header check for a received packet
	assign hdr_ok = (req_s1.frame_length >= ARP_MIN_LEN) &&
	                (req_s1.hw_type == HTYPE_ETH) &&
	                (req_s1.proto_type == PTYPE_IPV4) &&
	                (req_s1.hw_len == HLEN_ETH) &&
	                (req_s1.proto_len == PLEN_IPV4);

	assign reply = (req_s1.operation == OPER_REQUEST) && (req_s1.target_ip == own_ip_q);

	// Search by target on lookup, by sender when learning.
	assign key = (req_s1.kind == KIND_LOOKUP) ? req_s1.target_ip : req_s1.sender_ip;

	// Learn only as the request leaves the stage, so the next one sees the update.
	assign learn.en  = advance && (req_s1.kind == KIND_PACKET) && hdr_ok;
	assign learn.mac = req_s1.sender_mac;

	arpc_table #(
		.ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.learn  (learn),
		.look   (look)
	);

	// Build the result; transmit fields stay zero unless a frame goes out.
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ST_DROP;
		case (req_s1.kind)
			KIND_PACKET: begin
				if (hdr_ok) begin
					if (reply) begin
						rsp_d.status        = ST_REPLIED;
						rsp_d.tx_valid      = 1'b1;
						rsp_d.tx_dest_mac   = req_s1.sender_mac;
						rsp_d.tx_oper       = TX_OPER_REPLY;
						rsp_d.tx_target_mac = req_s1.sender_mac;
						rsp_d.tx_target_ip  = req_s1.sender_ip;
					end else begin
						rsp_d.status = ST_LEARNED;
					end
				end
			end
			KIND_LOOKUP: begin
				if (look.hit) begin
					rsp_d.status    = ST_HIT;
					rsp_d.found_mac = look.mac;
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			KIND_QUERY: begin
				rsp_d.status        = ST_REQUEST;
				rsp_d.tx_valid      = 1'b1;
				rsp_d.tx_dest_mac   = MAC_BROADCAST;
				rsp_d.tx_oper       = TX_OPER_REQUEST;
				rsp_d.tx_target_mac = '0;
				rsp_d.tx_target_ip  = req_s1.target_ip;
			end
			default: begin
				rsp_d.status  = ST_DROP;
				rsp_d.tx_oper = TX_OPER_NONE;
			end
		endcase
	end

	// Hold the result until taken; load a new one as the stage advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

endmodule

`default_nettype wire
